// ----- sv/dsha_pkg.sv -----
// package: sha-256 constants, round types and helper functions
`default_nettype none
package dsha_pkg;

  typedef logic [31:0] word_t;
  typedef word_t [7:0] state_t;
  typedef word_t [15:0] sched_t;

  localparam int unsigned NumRounds = 64;

  typedef enum logic [2:0] {
    REG_MID01  = 3'd0,
    REG_MID23  = 3'd1,
    REG_MID45  = 3'd2,
    REG_MID67  = 3'd3,
    REG_TAIL01 = 3'd4,
    REG_TAIL2  = 3'd5
  } cfg_reg_t;

  localparam word_t [63:0] RK = '{
    32'hc67178f2, 32'hbef9a3f7, 32'ha4506ceb, 32'h90befffa,
    32'h8cc70208, 32'h84c87814, 32'h78a5636f, 32'h748f82ee,
    32'h682e6ff3, 32'h5b9cca4f, 32'h4ed8aa4a, 32'h391c0cb3,
    32'h34b0bcb5, 32'h2748774c, 32'h1e376c08, 32'h19a4c116,
    32'h106aa070, 32'hf40e3585, 32'hd6990624, 32'hd192e819,
    32'hc76c51a3, 32'hc24b8b70, 32'ha81a664b, 32'ha2bfe8a1,
    32'h92722c85, 32'h81c2c92e, 32'h766a0abb, 32'h650a7354,
    32'h53380d13, 32'h4d2c6dfc, 32'h2e1b2138, 32'h27b70a85,
    32'h14292967, 32'h06ca6351, 32'hd5a79147, 32'hc6e00bf3,
    32'hbf597fc7, 32'hb00327c8, 32'ha831c66d, 32'h983e5152,
    32'h76f988da, 32'h5cb0a9dc, 32'h4a7484aa, 32'h2de92c6f,
    32'h240ca1cc, 32'h0fc19dc6, 32'hefbe4786, 32'he49b69c1,
    32'hc19bf174, 32'h9bdc06a7, 32'h80deb1fe, 32'h72be5d74,
    32'h550c7dc3, 32'h243185be, 32'h12835b01, 32'hd807aa98,
    32'hab1c5ed5, 32'h923f82a4, 32'h59f111f1, 32'h3956c25b,
    32'he9b5dba5, 32'hb5c0fbcf, 32'h71374491, 32'h428a2f98
  };

  localparam state_t IV = '{
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  function automatic word_t rotr(input word_t x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t bswap(input word_t x);
    bswap = {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

  // one compression round on the working state
  function automatic state_t round_fn(input state_t v, input word_t k, input word_t w);
    word_t t1;
    word_t t2;
    state_t r;
    t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
       + ((v[4] & v[5]) ^ (~v[4] & v[6])) + k + w;
    t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
       + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
    r[7] = v[6]; r[6] = v[5]; r[5] = v[4]; r[4] = v[3] + t1;
    r[3] = v[2]; r[2] = v[1]; r[1] = v[0]; r[0] = t1 + t2;
    round_fn = r;
  endfunction

  // advance the 16-word schedule window by one word
  function automatic sched_t sched_fn(input sched_t w);
    word_t lo;
    word_t hi;
    sched_t r;
    lo = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
    hi = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
    for (int i = 0; i < 15; i++) r[i] = w[i+1];
    r[15] = hi + w[9] + lo + w[0];
    sched_fn = r;
  endfunction

endpackage
`default_nettype wire

// ----- sv/dsha_round.sv -----
// pipeline stage: one sha-256 round with its schedule window
`default_nettype none
module dsha_round #(
  parameter int unsigned RoundIdx = 0
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    en,
  input  wire logic                    valid_in,
  input  wire dsha_pkg::state_t        v_in,
  input  wire dsha_pkg::state_t        init_in,
  input  wire dsha_pkg::sched_t        w_in,
  input  wire logic [31:0]             tag_in,
  output logic                         valid_out,
  output dsha_pkg::state_t             v_out,
  output dsha_pkg::state_t             init_out,
  output dsha_pkg::sched_t             w_out,
  output logic [31:0]                  tag_out
);

  // valid travels with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= valid_in;
    end
  end

  // round datapath
  always_ff @(posedge clk) begin
    if (en) begin
      v_out    <= dsha_pkg::round_fn(v_in, dsha_pkg::RK[RoundIdx], w_in[0]);
      w_out    <= dsha_pkg::sched_fn(w_in);
      init_out <= init_in;
      tag_out  <= tag_in;
    end
  end

endmodule
`default_nettype wire

// ----- sv/double_sha256_nonce_hasher_unit.sv -----
// top level: pipelined double sha-256 nonce scorer
//
// in_tdata carries a 32-bit nonce; each transaction yields exactly one result
// on out_tdata: the nonce echoed and the count of leading zero bits of the
// final hash read as a little-endian 256-bit number (0 to 256).
// the nonce is byte-swapped into word 3 of the second header block, which is
// compressed from the configured midstate; the digest is hashed once more.
// both hashes are fully unrolled: 128 round stages, one register each, plus
// one stage after each feed-forward add and one for the zero count.
// throughput is one nonce per cycle unless a stall on out_tready holds the
// pipeline.
// the result is held in an output register; when it is full and out_tready is
// low the whole pipeline freezes and in_tready falls; nothing is lost or repeated.
// in_tready is high whenever the output register is empty or is being read.
// reset clears all valid bits and the configuration registers to zero.
// configuration writes via cfg_we / cfg_index / cfg_wdata take effect at once
// and must only be made while the pipeline is empty.
`default_nettype none
module double_sha256_nonce_hasher_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] nonce
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // [31:0] nonce_echo, [40:32] zero_bits, rest zero
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_wdata
);

  localparam int unsigned NR = dsha_pkg::NumRounds;

  logic [63:0] cfg_r [6];
  logic        en;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) cfg_r[i] <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dsha_pkg::REG_MID01:  cfg_r[0] <= cfg_wdata;
        dsha_pkg::REG_MID23:  cfg_r[1] <= cfg_wdata;
        dsha_pkg::REG_MID45:  cfg_r[2] <= cfg_wdata;
        dsha_pkg::REG_MID67:  cfg_r[3] <= cfg_wdata;
        dsha_pkg::REG_TAIL01: cfg_r[4] <= cfg_wdata;
        dsha_pkg::REG_TAIL2:  cfg_r[5] <= {32'd0, cfg_wdata[31:0]};
        default: ;
      endcase
    end
  end

  // whole pipeline advances when the output slot is empty or being read
  assign en        = out_tready || !out_tvalid;
  assign in_tready = en;

  dsha_pkg::state_t mid;
  dsha_pkg::sched_t blk1;
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mid[2*i]   = cfg_r[i][63:32];
      mid[2*i+1] = cfg_r[i][31:0];
    end
    blk1     = '0;
    blk1[0]  = cfg_r[4][63:32];
    blk1[1]  = cfg_r[4][31:0];
    blk1[2]  = cfg_r[5][31:0];
    blk1[3]  = dsha_pkg::bswap(in_tdata);
    blk1[4]  = 32'h80000000;
    blk1[15] = 32'd640;
  end

  // first hash: 64 round stages
  logic             a_vld  [NR+1];
  dsha_pkg::state_t a_v    [NR+1];
  dsha_pkg::state_t a_init [NR+1];
  dsha_pkg::sched_t a_w    [NR+1];
  logic [31:0]      a_tag  [NR+1];

  assign a_vld[0]  = in_tvalid;
  assign a_v[0]    = mid;
  assign a_init[0] = mid;
  assign a_w[0]    = blk1;
  assign a_tag[0]  = in_tdata;

  for (genvar g = 0; g < NR; g++) begin : g_h1
    dsha_round #(.RoundIdx(g)) u_rnd (
      .clk(clk), .rst_n(rst_n), .en(en),
      .valid_in(a_vld[g]), .v_in(a_v[g]), .init_in(a_init[g]),
      .w_in(a_w[g]), .tag_in(a_tag[g]),
      .valid_out(a_vld[g+1]), .v_out(a_v[g+1]), .init_out(a_init[g+1]),
      .w_out(a_w[g+1]), .tag_out(a_tag[g+1])
    );
  end

  // feed-forward of first hash, register the digest
  logic             d1_vld_r;
  dsha_pkg::state_t d1_r;
  logic [31:0]      d1_tag_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_vld_r <= 1'b0;
    end else if (en) begin
      d1_vld_r <= a_vld[NR];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 8; i++) d1_r[i] <= a_v[NR][i] + a_init[NR][i];
      d1_tag_r <= a_tag[NR];
    end
  end

  dsha_pkg::sched_t blk2;
  always_comb begin
    blk2 = '0;
    for (int i = 0; i < 8; i++) blk2[i] = d1_r[i];
    blk2[8]  = 32'h80000000;
    blk2[15] = 32'd256;
  end

  // second hash: 64 round stages
  logic             b_vld  [NR+1];
  dsha_pkg::state_t b_v    [NR+1];
  dsha_pkg::state_t b_init [NR+1];
  dsha_pkg::sched_t b_w    [NR+1];
  logic [31:0]      b_tag  [NR+1];

  assign b_vld[0]  = d1_vld_r;
  assign b_v[0]    = dsha_pkg::IV;
  assign b_init[0] = dsha_pkg::IV;
  assign b_w[0]    = blk2;
  assign b_tag[0]  = d1_tag_r;

  for (genvar g = 0; g < NR; g++) begin : g_h2
    dsha_round #(.RoundIdx(g)) u_rnd (
      .clk(clk), .rst_n(rst_n), .en(en),
      .valid_in(b_vld[g]), .v_in(b_v[g]), .init_in(b_init[g]),
      .w_in(b_w[g]), .tag_in(b_tag[g]),
      .valid_out(b_vld[g+1]), .v_out(b_v[g+1]), .init_out(b_init[g+1]),
      .w_out(b_w[g+1]), .tag_out(b_tag[g+1])
    );
  end

  // feed-forward of second hash, byte order for little-endian reading
  logic         h2_vld_r;
  logic [255:0] h2_le_r;
  logic [31:0]  h2_tag_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h2_vld_r <= 1'b0;
    end else if (en) begin
      h2_vld_r <= b_vld[NR];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      // word 7 swapped lands in the top bits, word 0 in the bottom
      for (int i = 0; i < 8; i++) begin
        h2_le_r[32*i +: 32] <= dsha_pkg::bswap(b_v[NR][i] + b_init[NR][i]);
      end
      h2_tag_r <= b_tag[NR];
    end
  end

  // leading zero count: per-word counts then a priority pick
  logic [5:0] wz [8];
  logic [8:0] zcnt;
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      wz[i] = 6'd32;
      for (int b = 0; b < 32; b++) begin
        if (h2_le_r[32*i + b]) wz[i] = 6'(31 - b);
      end
    end
    zcnt = 9'd256;
    for (int i = 0; i < 8; i++) begin
      if (wz[i] != 6'd32) zcnt = 9'((7 - i) * 32) + {3'd0, wz[i]};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid <= 1'b0;
    end else if (en) begin
      out_tvalid <= h2_vld_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      out_tdata <= {7'd0, zcnt, h2_tag_r};
    end
  end

endmodule
`default_nettype wire
